// File: rtl/acpp_pkg.sv
package acpp_pkg;

	localparam int BYTE_W      = 8;
	localparam int COORD_W     = 10;
	localparam int OFFS_W      = 11;
	localparam int DIGIT_W     = 4;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 10;
	localparam int OUT_DATA_W  = 48;
	localparam int ACC_W       = 14;

	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

	localparam logic [COORD_W-1:0] COORD_MAX  = 10'd1023;
	localparam logic [COORD_W-1:0] LIMIT_RST  = 10'd240;
	localparam logic [COORD_W-1:0] CENTRE_RST = 10'd120;

	localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_X  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_Y  = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_X = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_Y = 8'd3;

	typedef enum logic [1:0] {
		TOK_DIGIT = 2'b00,
		TOK_COMMA = 2'b01,
		TOK_EOL   = 2'b10
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t           kind;
		logic [DIGIT_W-1:0]  digit;
	} token_t;

	typedef struct packed {
		logic [COORD_W-1:0] limit_x;
		logic [COORD_W-1:0] limit_y;
		logic [COORD_W-1:0] centre_x;
		logic [COORD_W-1:0] centre_y;
	} cfg_t;

	// Declared from the top bit down, so target_found lands in bit 0.
	typedef struct packed {
		logic [OFFS_W-1:0]  offset_y;
		logic [OFFS_W-1:0]  offset_x;
		logic [COORD_W-1:0] coord_y;
		logic [COORD_W-1:0] coord_x;
		logic               target_found;
	} result_t;

	localparam int PAD_W = OUT_DATA_W - $bits(result_t);

	// Decimal shift-in of one digit, saturating at the field maximum.
	function automatic logic [COORD_W-1:0] acc_digit(input logic [COORD_W-1:0] acc,
		input logic [DIGIT_W-1:0] d);
		logic [ACC_W-1:0] v;
		v = ACC_W'(acc) * ACC_W'(10) + ACC_W'(d);
		return (v > ACC_W'(COORD_MAX)) ? COORD_MAX : v[COORD_W-1:0];
	endfunction

endpackage

// File: rtl/acpp_front.sv
module acpp_front (
	input  logic                          in_valid,
	input  logic [acpp_pkg::BYTE_W-1:0]   in_byte,
	input  logic                          fifo_full,
	output logic                          in_ready,
	output logic                          push,
	output acpp_pkg::token_t              token
);
	import acpp_pkg::*;

	logic keep;

	always_comb begin
		token.kind  = TOK_DIGIT;
		token.digit = in_byte[DIGIT_W-1:0];
		keep        = 1'b0;
		if (in_byte == CHAR_LF || in_byte == CHAR_CR) begin
			token.kind = TOK_EOL;
			keep       = 1'b1;
		end else if (in_byte == CHAR_COMMA) begin
			token.kind = TOK_COMMA;
			keep       = 1'b1;
		end else if (in_byte >= CHAR_ZERO && in_byte <= CHAR_NINE) begin
			keep = 1'b1;
		end
	end

	// Ignored bytes are taken but never reach the queue.
	assign in_ready = !fifo_full;
	assign push     = in_valid && in_ready && keep;

endmodule

// File: rtl/acpp_fifo.sv
module acpp_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  acpp_pkg::token_t wr_token,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output acpp_pkg::token_t rd_token
);
	import acpp_pkg::*;

	token_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_token  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_token;
	end

endmodule

// File: rtl/acpp_back.sv
module acpp_back #(
	parameter int BUFFER_BYTES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	input  acpp_pkg::token_t  token,
	input  acpp_pkg::cfg_t    cfg,
	input  logic              out_ready,
	output logic              pop,
	output logic              out_valid,
	output acpp_pkg::result_t out_result
);
	import acpp_pkg::*;

	localparam int CW = $clog2(BUFFER_BYTES);
	localparam logic [CW-1:0] KEPT_LIMIT = CW'(BUFFER_BYTES - 1);

	logic [COORD_W-1:0] first_value_q;
	logic [COORD_W-1:0] second_value_q;
	logic               comma_seen_q;
	logic               second_closed_q;
	logic [CW-1:0]      kept_count_q;
	logic               out_valid_q;
	result_t            out_result_q;

	logic               can_load;
	logic               emit;
	logic [CW-1:0]      kept_next;
	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;
	result_t            res;

	assign can_load  = !out_valid_q || out_ready;
	assign pop       = tok_valid && (token.kind != TOK_EOL || can_load);
	assign kept_next = kept_count_q + CW'(1);
	assign emit      = (kept_count_q != '0) && comma_seen_q;

	always_comb begin
		cx = (first_value_q > cfg.limit_x) ? cfg.limit_x : first_value_q;
		cy = (second_value_q > cfg.limit_y) ? cfg.limit_y : second_value_q;
		res = '0;
		if (first_value_q != '0 || second_value_q != '0) begin
			res.target_found = 1'b1;
			res.coord_x      = cx;
			res.coord_y      = cy;
			res.offset_x     = {1'b0, cx} - {1'b0, cfg.centre_x};
			res.offset_y     = {1'b0, cy} - {1'b0, cfg.centre_y};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_value_q   <= '0;
			second_value_q  <= '0;
			comma_seen_q    <= 1'b0;
			second_closed_q <= 1'b0;
			kept_count_q    <= '0;
		end else if (pop) begin
			unique case (token.kind) inside
				TOK_EOL: begin
					first_value_q   <= '0;
					second_value_q  <= '0;
					comma_seen_q    <= 1'b0;
					second_closed_q <= 1'b0;
					kept_count_q    <= '0;
				end
				TOK_COMMA, TOK_DIGIT: begin
					// A line reaching BUFFER_BYTES-1 kept tokens has its state cleared.
					if (kept_next == KEPT_LIMIT) begin
						first_value_q   <= '0;
						second_value_q  <= '0;
						comma_seen_q    <= 1'b0;
						second_closed_q <= 1'b0;
						kept_count_q    <= '0;
					end else begin
						kept_count_q <= kept_next;
						if (token.kind == TOK_COMMA) begin
							if (!comma_seen_q)
								comma_seen_q <= 1'b1;
							else
								second_closed_q <= 1'b1;
						end else if (!comma_seen_q) begin
							first_value_q <= acc_digit(first_value_q, token.digit);
						end else if (!second_closed_q) begin
							second_value_q <= acc_digit(second_value_q, token.digit);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop && token.kind == TOK_EOL && emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop && token.kind == TOK_EOL && emit)
			out_result_q <= res;
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_result_q;

endmodule

// File: rtl/ascii_coordinate_pair_parser_unit.sv
// Channel   Direction  Signals                                   Content
// s_axis    in         s_tvalid s_tready s_tdata[7:0]            rx_byte
// m_axis    out        m_tvalid m_tready m_tdata[47:0]           result (see port)
// cfg       in         cfg_valid cfg_ready cfg_index cfg_data    register write
//
// One byte is taken per cycle while the queue is not full; a CR or LF byte ending a
// reporting line passes through a queue entry, then the output register, to m_tvalid.
// The front classifies bytes, the back accumulates and builds results.
// The output register stalls only the back; the queue lets the front keep taking
// bytes until it fills. arst_n clears line state and loads the register defaults.
module ascii_coordinate_pair_parser_unit #(
	parameter int BUFFER_BYTES = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [acpp_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] rx_byte
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] target_found, [10:1] coord_x, [20:11] coord_y, [31:21] offset_x,
	// [42:32] offset_y, [47:43] zero
	output logic [acpp_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [acpp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [acpp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import acpp_pkg::*;

	cfg_t    cfg_q;
	token_t  front_token;
	token_t  queue_token;
	logic    push;
	logic    pop;
	logic    fifo_full;
	logic    fifo_not_empty;
	result_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_x  <= LIMIT_RST;
			cfg_q.limit_y  <= LIMIT_RST;
			cfg_q.centre_x <= CENTRE_RST;
			cfg_q.centre_y <= CENTRE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIMIT_X:  cfg_q.limit_x  <= cfg_data;
				REG_LIMIT_Y:  cfg_q.limit_y  <= cfg_data;
				REG_CENTRE_X: cfg_q.centre_x <= cfg_data;
				REG_CENTRE_Y: cfg_q.centre_y <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	acpp_front u_front (
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.fifo_full (fifo_full),
		.in_ready  (s_tready),
		.push      (push),
		.token     (front_token)
	);

	acpp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_token  (front_token),
		.pop       (pop),
		.full      (fifo_full),
		.not_empty (fifo_not_empty),
		.rd_token  (queue_token)
	);

	acpp_back #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (fifo_not_empty),
		.token      (queue_token),
		.cfg        (cfg_q),
		.out_ready  (m_tready),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_result (result)
	);

	assign m_tdata = {PAD_W'(0), result};

endmodule

// File: rtl/acpp_checker.sv
module acpp_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [acpp_pkg::BYTE_W-1:0]          s_tdata,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [acpp_pkg::OUT_DATA_W-1:0]      m_tdata,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic [acpp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input logic [acpp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import acpp_pkg::*;

	// A stalled result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A line of 0,0 reports no target and carries all-zero coordinates and offsets.
	a_no_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[OUT_DATA_W-1:1] == '0)
		else $error("no-target result carries non-zero fields");

	// The padding above the result fields is always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:$bits(result_t)] == '0)
		else $error("padding bits set in result");

	// Register writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind ascii_coordinate_pair_parser_unit acpp_checker u_acpp_checker (.*);
